### rtl/trtp_pkg.sv
// Package for the tagged record table parser: phase codes, result kinds,
// error codes, register indexes, tags and the result beat type.
// No dependencies.
package trtp_pkg;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_HDR  = 7'b0000010,
    PH_REC  = 7'b0000100,
    PH_NAME = 7'b0001000,
    PH_PAD  = 7'b0010000,
    PH_GOB  = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_t;

  localparam logic [1:0] RK_CHAR    = 2'd0;
  localparam logic [1:0] RK_RECORD  = 2'd1;
  localparam logic [1:0] RK_SUCCESS = 2'd2;
  localparam logic [1:0] RK_ERROR   = 2'd3;

  localparam logic [3:0] ERR_TOO_SMALL    = 4'd0;
  localparam logic [3:0] ERR_HEADER_WORD  = 4'd1;
  localparam logic [3:0] ERR_NO_TER       = 4'd2;
  localparam logic [3:0] ERR_COUNT_LIMIT  = 4'd3;
  localparam logic [3:0] ERR_COUNT_SPACE  = 4'd4;
  localparam logic [3:0] ERR_REC_TRUNC    = 4'd5;
  localparam logic [3:0] ERR_NONPRINTABLE = 4'd6;
  localparam logic [3:0] ERR_NAME_LONG    = 4'd7;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd8;
  localparam logic [3:0] ERR_EMPTY_NAME   = 4'd9;
  localparam logic [3:0] ERR_PAD_PAST_END = 4'd10;
  localparam logic [3:0] ERR_NO_GOB       = 4'd11;

  localparam logic [1:0] REG_STREAM_LENGTH   = 2'd0;
  localparam logic [1:0] REG_HEADER_WORD     = 2'd1;
  localparam logic [1:0] REG_MAX_RECORDS     = 2'd2;
  localparam logic [1:0] REG_MAX_NAME_LENGTH = 2'd3;

  localparam logic [31:0] HEADER_WORD_RESET = 32'd70;
  localparam logic [20:0] MAX_RECORDS_RESET = 21'h10_0000;
  localparam logic [12:0] MAX_NAME_RESET    = 13'd4096;

  localparam logic [31:0] TAG_TER    = 32'h3A52_4554;
  localparam logic [31:0] TAG_GOB    = 32'h3A42_4F47;
  localparam logic [31:0] MIN_LENGTH = 32'd16;
  localparam logic [7:0]  CHAR_LO    = 8'h20;
  localparam logic [7:0]  CHAR_HI    = 8'h7E;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [31:0] record_kind;
    logic [31:0] record_index;
    logic [12:0] name_length;
    logic [31:0] offset;
    logic        pad_nonzero;
    logic [20:0] nonzero_pad_records;
    logic [3:0]  error_code;
    logic        last;
  } result_t;

  function automatic result_t error_result(input logic [3:0] code);
    result_t r;
    r = '0;
    r.kind = RK_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

### rtl/tagged_record_table_parser_core.sv
// Top level of the tagged record table parser: byte-wise parse logic,
// configuration registers and a four-entry result queue.
// Depends on trtp_pkg.

// Takes one buffer byte per beat, one beat per cycle, and parses it in a single
// registered step. A byte gives zero, one or two result beats; they go into a
// four-entry result queue, and the input is stalled while the queue holds more
// than two entries, so the sustained rate is one byte per cycle as long as the
// output side takes one result per cycle. Each result is registered into the
// queue and reaches the output behind any earlier queued beats. The configuration
// registers may be written between bytes; the current stream_length is used as is.
module tagged_record_table_parser_core
  import trtp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  name_char,
  output logic [31:0] record_kind,
  output logic [31:0] record_index,
  output logic [12:0] name_length,
  output logic [31:0] offset,
  output logic        pad_nonzero,
  output logic [20:0] nonzero_pad_records,
  output logic [3:0]  error_code,
  output logic        last_of_run
);

  localparam int OFF_KEEP = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam logic [31:0] OFF_MASK = 32'hFFFF_FFFF >> (32 - OFF_KEEP);
  localparam int POS_W = 34;
  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  // configuration
  logic [31:0] stream_length;
  logic [31:0] header_word;
  logic [20:0] max_records;
  logic [12:0] max_name_length;

  // parse state
  phase_t      phase;
  logic [POS_W-1:0] position;
  logic [23:0] word_assembly;
  logic [31:0] kind_latch;
  logic [31:0] index_latch;
  logic [20:0] declared_count;
  logic [20:0] records_done;
  logic [12:0] name_chars;
  logic [31:0] name_base;
  logic        pad_seen_nonzero;
  logic [20:0] nonzero_pad_total;
  logic [2:0]  sub_count;
  logic [1:0]  pad_left;

  phase_t      phase_next;
  logic [POS_W-1:0] position_next;
  logic [23:0] word_assembly_next;
  logic [31:0] kind_latch_next;
  logic [31:0] index_latch_next;
  logic [20:0] declared_count_next;
  logic [20:0] records_done_next;
  logic [12:0] name_chars_next;
  logic [31:0] name_base_next;
  logic        pad_seen_nonzero_next;
  logic [20:0] nonzero_pad_total_next;
  logic [2:0]  sub_count_next;
  logic [1:0]  pad_left_next;

  result_t     res [2];
  logic [1:0]  n_res;

  // result queue
  result_t     queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fifo_count;

  logic accept;
  logic pop;

  assign in_stall  = fifo_count > (PTR_W+1)'(DEPTH - 2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = fifo_count != '0;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length   <= '0;
      header_word     <= HEADER_WORD_RESET;
      max_records     <= MAX_RECORDS_RESET;
      max_name_length <= MAX_NAME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STREAM_LENGTH:   stream_length   <= cfg_data;
        REG_HEADER_WORD:     header_word     <= cfg_data;
        REG_MAX_RECORDS:     max_records     <= cfg_data[20:0];
        REG_MAX_NAME_LENGTH: max_name_length <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] p1;
    logic [POS_W:0]   len_w;
    logic [POS_W:0]   aligned;
    logic [31:0]      word;
    logic [1:0]       idx;
    logic [20:0]      cnt21;
    logic [24:0]      cnt9;
    logic             active;
    logic             do_finish;
    logic             do_begin;
    result_t          rec;

    phase_next             = phase;
    position_next          = position;
    word_assembly_next     = word_assembly;
    kind_latch_next        = kind_latch;
    index_latch_next       = index_latch;
    declared_count_next    = declared_count;
    records_done_next      = records_done;
    name_chars_next        = name_chars;
    name_base_next         = name_base;
    pad_seen_nonzero_next  = pad_seen_nonzero;
    nonzero_pad_total_next = nonzero_pad_total;
    sub_count_next         = sub_count;
    pad_left_next          = pad_left;
    res[0]    = '0;
    res[1]    = '0;
    n_res     = '0;
    do_finish = 1'b0;
    do_begin  = 1'b0;
    active    = 1'b0;
    rec       = '0;
    len_w     = {3'b000, stream_length};
    aligned   = '0;
    cnt21     = '0;
    cnt9      = '0;

    if (first) begin
      phase_next             = PH_HDR;
      position_next          = '0;
      word_assembly_next     = '0;
      kind_latch_next        = '0;
      index_latch_next       = '0;
      declared_count_next    = '0;
      records_done_next      = '0;
      name_chars_next        = '0;
      name_base_next         = '0;
      pad_seen_nonzero_next  = 1'b0;
      nonzero_pad_total_next = '0;
      sub_count_next         = '0;
      pad_left_next          = '0;
      if (stream_length < MIN_LENGTH) begin
        res[0]     = error_result(ERR_TOO_SMALL);
        n_res      = 2'd1;
        phase_next = PH_DONE;
      end else begin
        active = 1'b1;
      end
    end else if (phase != PH_IDLE && phase != PH_DONE) begin
      active = 1'b1;
    end

    p    = position_next;
    p1   = p + POS_W'(1);
    idx  = (phase_next == PH_HDR) ? p[1:0] : sub_count_next[1:0];
    word = {data_byte, word_assembly_next};

    if (active) begin
      if (idx != 2'd3 && (phase_next == PH_HDR || phase_next == PH_REC ||
                          phase_next == PH_GOB)) begin
        word_assembly_next[8*idx +: 8] = data_byte;
      end
      case (phase_next)
        PH_HDR: begin
          if (p == POS_W'(3)) begin
            word_assembly_next = '0;
            if (word != header_word) begin
              res[n_res[0]] = error_result(ERR_HEADER_WORD);
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end
          end else if (p == POS_W'(7)) begin
            word_assembly_next = '0;
            if (word != TAG_TER) begin
              res[n_res[0]] = error_result(ERR_NO_TER);
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end
          end else if (p == POS_W'(11)) begin
            word_assembly_next = '0;
            cnt21 = word[20:0];
            cnt9  = 25'({cnt21, 3'b000}) + 25'(cnt21);
            if (word > {11'b0, max_records}) begin
              res[n_res[0]] = error_result(ERR_COUNT_LIMIT);
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end else if (stream_length >= 32'd12 &&
                         {7'b0, cnt9} > stream_length - 32'd12) begin
              res[n_res[0]] = error_result(ERR_COUNT_SPACE);
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end else begin
              declared_count_next = cnt21;
              do_begin = 1'b1;
            end
          end
        end
        PH_REC: begin
          if (sub_count_next == 3'd3) begin
            kind_latch_next    = word;
            word_assembly_next = '0;
          end else if (sub_count_next == 3'd7) begin
            index_latch_next      = word;
            word_assembly_next    = '0;
            name_chars_next       = '0;
            name_base_next        = p1[31:0];
            pad_seen_nonzero_next = 1'b0;
            if ({1'b0, p1} >= len_w) begin
              res[n_res[0]] = error_result(ERR_UNTERMINATED);
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_NAME;
            end
          end
          sub_count_next = sub_count_next + 3'd1;
        end
        PH_NAME: begin
          if (data_byte == 8'd0) begin
            aligned = ({1'b0, p} + (POS_W+1)'(4)) & ~(POS_W+1)'(3);
            if (name_chars_next == '0) begin
              res[n_res[0]] = error_result(ERR_EMPTY_NAME);
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end else if (aligned > len_w) begin
              res[n_res[0]] = error_result(ERR_PAD_PAST_END);
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end else if (aligned == {1'b0, p1}) begin
              do_finish = 1'b1;
            end else begin
              pad_left_next = 2'(aligned - {1'b0, p1});
              phase_next    = PH_PAD;
            end
          end else if (data_byte < CHAR_LO || data_byte > CHAR_HI) begin
            res[n_res[0]] = error_result(ERR_NONPRINTABLE);
            n_res = n_res + 2'd1;
            phase_next = PH_DONE;
          end else if (name_chars_next >= max_name_length) begin
            res[n_res[0]] = error_result(ERR_NAME_LONG);
            n_res = n_res + 2'd1;
            phase_next = PH_DONE;
          end else begin
            rec           = '0;
            rec.kind      = RK_CHAR;
            rec.name_char = data_byte;
            res[n_res[0]] = rec;
            n_res = n_res + 2'd1;
            name_chars_next = name_chars_next + 13'd1;
            if ({1'b0, p1} >= len_w) begin
              res[n_res[0]] = error_result(ERR_UNTERMINATED);
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end
          end
        end
        PH_PAD: begin
          if (data_byte != 8'd0) pad_seen_nonzero_next = 1'b1;
          if (pad_left_next != 2'd0) pad_left_next = pad_left_next - 2'd1;
          if (pad_left_next == 2'd0) do_finish = 1'b1;
        end
        PH_GOB: begin
          if (sub_count_next[1:0] == 2'd3) begin
            word_assembly_next = '0;
            if (word != TAG_GOB) begin
              res[n_res[0]] = error_result(ERR_NO_GOB);
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end else begin
              rec        = '0;
              rec.kind   = RK_SUCCESS;
              rec.offset = (p[31:0] - 32'd3) & OFF_MASK;
              res[n_res[0]] = rec;
              n_res = n_res + 2'd1;
              phase_next = PH_DONE;
            end
          end
          sub_count_next = sub_count_next + 3'd1;
        end
        default: ;
      endcase

      if (do_finish) begin
        records_done_next = records_done_next + 21'd1;
        if (pad_seen_nonzero_next) nonzero_pad_total_next = nonzero_pad_total_next + 21'd1;
        rec                     = '0;
        rec.kind                = RK_RECORD;
        rec.record_kind         = kind_latch_next;
        rec.record_index        = index_latch_next;
        rec.name_length         = name_chars_next;
        rec.offset              = name_base_next & OFF_MASK;
        rec.pad_nonzero         = pad_seen_nonzero_next;
        rec.nonzero_pad_records = nonzero_pad_total_next;
        res[n_res[0]] = rec;
        n_res = n_res + 2'd1;
        do_begin = 1'b1;
      end

      if (do_begin) begin
        word_assembly_next = '0;
        sub_count_next     = '0;
        if (records_done_next >= declared_count_next) begin
          if ({1'b0, p1} + (POS_W+1)'(4) > len_w) begin
            res[n_res[0]] = error_result(ERR_NO_GOB);
            n_res = n_res + 2'd1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_GOB;
          end
        end else if ({1'b0, p1} + (POS_W+1)'(8) > len_w) begin
          res[n_res[0]] = error_result(ERR_REC_TRUNC);
          n_res = n_res + 2'd1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_REC;
        end
      end

      position_next = p1;
    end

    if (n_res == 2'd1) res[0].last = 1'b1;
    if (n_res == 2'd2) res[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      position          <= '0;
      word_assembly     <= '0;
      kind_latch        <= '0;
      index_latch       <= '0;
      declared_count    <= '0;
      records_done      <= '0;
      name_chars        <= '0;
      name_base         <= '0;
      pad_seen_nonzero  <= 1'b0;
      nonzero_pad_total <= '0;
      sub_count         <= '0;
      pad_left          <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      position          <= position_next;
      word_assembly     <= word_assembly_next;
      kind_latch        <= kind_latch_next;
      index_latch       <= index_latch_next;
      declared_count    <= declared_count_next;
      records_done      <= records_done_next;
      name_chars        <= name_chars_next;
      name_base         <= name_base_next;
      pad_seen_nonzero  <= pad_seen_nonzero_next;
      nonzero_pad_total <= nonzero_pad_total_next;
      sub_count         <= sub_count_next;
      pad_left          <= pad_left_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) queue[wr_ptr] <= res[0];
    if (accept && n_res == 2'd2) queue[wr_ptr + PTR_W'(1)] <= res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + PTR_W'(n_res);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      fifo_count <= fifo_count + (accept ? (PTR_W+1)'(n_res) : '0)
                    - (PTR_W+1)'(pop);
    end
  end

  assign result_kind         = queue[rd_ptr].kind;
  assign name_char           = queue[rd_ptr].name_char;
  assign record_kind         = queue[rd_ptr].record_kind;
  assign record_index        = queue[rd_ptr].record_index;
  assign name_length         = queue[rd_ptr].name_length;
  assign offset              = queue[rd_ptr].offset;
  assign pad_nonzero         = queue[rd_ptr].pad_nonzero;
  assign nonzero_pad_records = queue[rd_ptr].nonzero_pad_records;
  assign error_code          = queue[rd_ptr].error_code;
  assign last_of_run         = queue[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= (PTR_W+1)'(DEPTH))
    else $error("result queue overflow");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    (accept && n_res != 2'd0) |=> out_valid)
    else $error("result beat lost");

  a_record_open: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NAME || phase == PH_PAD) |-> records_done < declared_count)
    else $error("record in progress beyond declared count");

  a_pad_due: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAD) |-> pad_left != 2'd0)
    else $error("padding phase with nothing due");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == RK_ERROR) |-> last_of_run)
    else $error("error beat not last of run");

endmodule

### verif/testbench.sv
// Testbench for tagged_record_table_parser_core: feeds record tables one byte
// per beat, predicts every result beat with a local parser model and checks it.
// Depends on trtp_pkg and the core.
module testbench;
  import trtp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_TARGET    = 1550;
  localparam int HOLD_CYCLES    = 200;

  typedef struct packed {
    logic [7:0] value;
    logic       start;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        first = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  name_char;
  logic [31:0] record_kind;
  logic [31:0] record_index;
  logic [12:0] name_length;
  logic [31:0] offset;
  logic        pad_nonzero;
  logic [20:0] nonzero_pad_records;
  logic [3:0]  error_code;
  logic        last_of_run;

  // parser model state and register copies
  phase_t      ps_phase;
  logic [63:0] ps_pos, ps_name_base, ps_pad_left;
  logic [31:0] ps_word, ps_kind, ps_index;
  logic [20:0] ps_declared, ps_records, ps_pad_total;
  logic [12:0] ps_chars;
  logic        ps_pad_dirty;
  logic [2:0]  ps_sub;
  logic [31:0] cf_length, cf_header;
  logic [20:0] cf_max_records;
  logic [12:0] cf_max_name;

  result_t     step_beats[$];
  result_t     parsed_results[$];
  byte_item_t  byte_queue[$];
  logic [7:0]  frame[$];

  int items_taken = 0;
  int mismatches = 0;
  int beats_seen = 0;
  int quiet_cycles = 0;
  int in_gap_left = 0;
  int out_gap_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int in_gap_pct = 0;
  int out_gap_pct = 0;
  bit calm = 1'b0;

  tagged_record_table_parser_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .first(first),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .name_char(name_char),
    .record_kind(record_kind),
    .record_index(record_index),
    .name_length(name_length),
    .offset(offset),
    .pad_nonzero(pad_nonzero),
    .nonzero_pad_records(nonzero_pad_records),
    .error_code(error_code),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task parse_fail(input logic [3:0] code);
    result_t r;
    r = '0;
    r.kind = RK_ERROR;
    r.error_code = code;
    step_beats = {step_beats, r};
    ps_phase = PH_DONE;
  endtask

  task next_record(input logic [63:0] cursor);
    logic [63:0] len;
    len = {32'd0, cf_length};
    ps_word = '0;
    ps_sub = '0;
    if (ps_records >= ps_declared) begin
      if (cursor > len || len - cursor < 64'd4) parse_fail(ERR_NO_GOB);
      else ps_phase = PH_GOB;
    end else if (cursor > len || len - cursor < 64'd8) begin
      parse_fail(ERR_REC_TRUNC);
    end else begin
      ps_phase = PH_REC;
    end
  endtask

  task close_record(input logic [63:0] cursor);
    result_t r;
    ps_records = ps_records + 21'd1;
    if (ps_pad_dirty) ps_pad_total = ps_pad_total + 21'd1;
    r = '0;
    r.kind = RK_RECORD;
    r.record_kind = ps_kind;
    r.record_index = ps_index;
    r.name_length = ps_chars;
    r.offset = ps_name_base[31:0];
    r.pad_nonzero = ps_pad_dirty;
    r.nonzero_pad_records = ps_pad_total;
    step_beats = {step_beats, r};
    next_record(cursor);
  endtask

  task parse_byte(input logic [7:0] b, input logic start);
    logic [63:0] p, len, aligned, cnt;
    logic [31:0] lane;
    result_t     r;
    bit          too_small;
    if (!start && (ps_phase == PH_IDLE || ps_phase == PH_DONE)) return;
    step_beats.delete();
    len = {32'd0, cf_length};
    too_small = 1'b0;
    if (start) begin
      ps_phase = PH_HDR;
      ps_pos = '0;
      ps_word = '0;
      ps_kind = '0;
      ps_index = '0;
      ps_declared = '0;
      ps_records = '0;
      ps_chars = '0;
      ps_name_base = '0;
      ps_pad_dirty = 1'b0;
      ps_pad_total = '0;
      ps_sub = '0;
      ps_pad_left = '0;
      if (cf_length < MIN_LENGTH) begin
        parse_fail(ERR_TOO_SMALL);
        too_small = 1'b1;
      end
    end
    if (!too_small) begin
      p = ps_pos;
      case (ps_phase)
        PH_HDR: begin
          lane = {24'd0, b} << {p[1:0], 3'b000};
          ps_word = ps_word | lane;
          if (p == 64'd3) begin
            if (ps_word != cf_header) parse_fail(ERR_HEADER_WORD);
            ps_word = '0;
          end else if (p == 64'd7) begin
            if (ps_word != TAG_TER) parse_fail(ERR_NO_TER);
            ps_word = '0;
          end else if (p == 64'd11) begin
            cnt = {32'd0, ps_word};
            ps_word = '0;
            if (cnt > {43'd0, cf_max_records}) parse_fail(ERR_COUNT_LIMIT);
            else if (cnt * 64'd9 > len - 64'd12) parse_fail(ERR_COUNT_SPACE);
            else begin
              ps_declared = cnt[20:0];
              next_record(p + 64'd1);
            end
          end
        end
        PH_REC: begin
          lane = {24'd0, b} << {ps_sub[1:0], 3'b000};
          ps_word = ps_word | lane;
          if (ps_sub == 3'd3) begin
            ps_kind = ps_word;
            ps_word = '0;
          end else if (ps_sub == 3'd7) begin
            ps_index = ps_word;
            ps_word = '0;
            ps_chars = '0;
            ps_name_base = p + 64'd1;
            ps_pad_dirty = 1'b0;
            if (p + 64'd1 >= len) parse_fail(ERR_UNTERMINATED);
            else ps_phase = PH_NAME;
          end
          ps_sub = ps_sub + 3'd1;
        end
        PH_NAME: begin
          if (b == 8'd0) begin
            aligned = (p + 64'd4) & ~64'd3;
            if (ps_chars == 13'd0) parse_fail(ERR_EMPTY_NAME);
            else if (aligned > len) parse_fail(ERR_PAD_PAST_END);
            else if (aligned == p + 64'd1) close_record(p + 64'd1);
            else begin
              ps_pad_left = aligned - (p + 64'd1);
              ps_phase = PH_PAD;
            end
          end else if (b < CHAR_LO || b > CHAR_HI) begin
            parse_fail(ERR_NONPRINTABLE);
          end else if (ps_chars >= cf_max_name) begin
            parse_fail(ERR_NAME_LONG);
          end else begin
            r = '0;
            r.kind = RK_CHAR;
            r.name_char = b;
            step_beats = {step_beats, r};
            ps_chars = ps_chars + 13'd1;
            if (p + 64'd1 >= len) parse_fail(ERR_UNTERMINATED);
          end
        end
        PH_PAD: begin
          if (b != 8'd0) ps_pad_dirty = 1'b1;
          if (ps_pad_left > 0) ps_pad_left = ps_pad_left - 64'd1;
          if (ps_pad_left == 0) close_record(p + 64'd1);
        end
        PH_GOB: begin
          lane = {24'd0, b} << {ps_sub[1:0], 3'b000};
          ps_word = ps_word | lane;
          if (ps_sub == 3'd3) begin
            if (ps_word != TAG_GOB) parse_fail(ERR_NO_GOB);
            else begin
              r = '0;
              r.kind = RK_SUCCESS;
              r.offset = p[31:0] - 32'd3;
              step_beats = {step_beats, r};
              ps_phase = PH_DONE;
            end
            ps_word = '0;
          end
          ps_sub = (ps_sub + 3'd1) & 3'd3;
        end
        default: ;
      endcase
      ps_pos = p + 64'd1;
    end
    foreach (step_beats[i]) begin
      r = step_beats[i];
      r.last = (i == step_beats.size() - 1);
      parsed_results = {parsed_results, r};
    end
  endtask

  task report(input string msg);
    $display("mismatch at result beat %0d: %s", beats_seen, msg);
    mismatches++;
  endtask

  task check_field(input string field, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", field, got, want));
  endtask

  task write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_STREAM_LENGTH:   cf_length = value;
      REG_HEADER_WORD:     cf_header = value;
      REG_MAX_RECORDS:     cf_max_records = value[20:0];
      REG_MAX_NAME_LENGTH: cf_max_name = value[12:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // wait for every byte and result to pass, then let the core settle
  task drain();
    while (byte_queue.size() != 0 || in_valid || parsed_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) frame = {frame, w[8*k +: 8]};
  endtask

  task build_frame(input int nrec, input int nmin, input int nmax, input bit dirty);
    int n;
    frame.delete();
    push_word(cf_header);
    push_word(TAG_TER);
    push_word(nrec);
    for (int r = 0; r < nrec; r++) begin
      push_word($urandom);
      push_word($urandom);
      n = $urandom_range(nmin, nmax);
      repeat (n) frame = {frame, 8'($urandom_range(CHAR_LO, CHAR_HI))};
      frame = {frame, 8'd0};
      while (frame.size() % 4 != 0)
        frame = {frame, (dirty && $urandom_range(0, 1)) ?
                        8'($urandom_range(1, 255)) : 8'd0};
    end
    push_word(TAG_GOB);
  endtask

  task send_span(input int from, input int upto, input bit restart);
    byte_item_t item;
    for (int i = from; i < upto && i < frame.size(); i++) begin
      item.value = frame[i];
      item.start = restart && (i == from);
      byte_queue = {byte_queue, item};
    end
  endtask

  task push_noise(input int n);
    byte_item_t item;
    repeat (n) begin
      item.value = 8'($urandom_range(0, 255));
      item.start = 1'b0;
      byte_queue = {byte_queue, item};
    end
  endtask

  task run_frame(input logic [31:0] len, input int upto);
    drain();
    write_reg(REG_STREAM_LENGTH, len);
    send_span(0, upto, 1'b1);
  endtask

  // sender
  always @(posedge clk) begin : sender
    byte_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        items_taken++;
        parse_byte(data_byte, first);
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0 && !calm && $urandom_range(0, 99) < in_gap_pct) begin
          in_gap_left = $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          item = byte_queue.pop_front();
          data_byte <= item.value;
          first <= item.start;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : receiver
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parsed_results.size() == 0) begin
          report($sformatf("unexpected beat of kind %0d", result_kind));
        end else begin
          want = parsed_results.pop_front();
          check_field("result_kind", 32'(result_kind), 32'(want.kind));
          check_field("name_char", 32'(name_char), 32'(want.name_char));
          check_field("record_kind", record_kind, want.record_kind);
          check_field("record_index", record_index, want.record_index);
          check_field("name_length", 32'(name_length), 32'(want.name_length));
          check_field("offset", offset, want.offset);
          check_field("pad_nonzero", 32'(pad_nonzero), 32'(want.pad_nonzero));
          check_field("nonzero_pad_records", 32'(nonzero_pad_records),
                      32'(want.nonzero_pad_records));
          check_field("error_code", 32'(error_code), 32'(want.error_code));
          check_field("last_of_run", 32'(last_of_run), 32'(want.last));
        end
        beats_seen++;
      end
      // long hold-off so the core backs up into its input
      if (hold_left == 0 && holds_done < 2 && in_valid && byte_queue.size() >= 16 &&
          beats_seen >= 40 + holds_done * 300) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_gap_left > 0) begin
        out_gap_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < out_gap_pct) begin
        out_gap_left = $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int target, nrec, cap, mode, cut, n, frames;
    logic [31:0] len, value;
    cf_length = '0;
    cf_header = HEADER_WORD_RESET;
    cf_max_records = MAX_RECORDS_RESET;
    cf_max_name = MAX_NAME_RESET;
    ps_phase = PH_IDLE;
    ps_pos = '0;
    ps_word = '0;
    ps_kind = '0;
    ps_index = '0;
    ps_declared = '0;
    ps_records = '0;
    ps_chars = '0;
    ps_name_base = '0;
    ps_pad_dirty = 1'b0;
    ps_pad_total = '0;
    ps_sub = '0;
    ps_pad_left = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    in_gap_pct = 10;
    out_gap_pct = 10;

    // too small, with ignored bytes while idle
    push_noise(2);
    build_frame(0, 1, 1, 1'b0);
    run_frame(32'd0, 1);
    build_frame(1, 3, 3, 1'b0);
    run_frame(32'd15, 2);
    // header word mismatch
    drain();
    write_reg(REG_HEADER_WORD, 32'd0);
    build_frame(1, 2, 2, 1'b0);
    frame[0] = 8'h01;
    run_frame(frame.size(), frame.size());
    // full-scale fields, nonzero padding, unbounded length
    drain();
    write_reg(REG_HEADER_WORD, 32'hFFFF_FFFF);
    build_frame(2, 1, 1, 1'b1);
    for (int i = 12; i < 16; i++) frame[i] = 8'hFF;
    for (int i = 16; i < 20; i++) frame[i] = 8'h00;
    frame[22] = 8'hFF;
    run_frame(32'hFFFF_FFFF, frame.size());
    // missing TER
    drain();
    write_reg(REG_HEADER_WORD, HEADER_WORD_RESET);
    build_frame(0, 1, 1, 1'b0);
    frame[5] = 8'h00;
    run_frame(frame.size(), frame.size());
    // count over limit
    drain();
    write_reg(REG_MAX_RECORDS, 32'd0);
    build_frame(1, 1, 1, 1'b0);
    run_frame(frame.size(), frame.size());
    drain();
    write_reg(REG_MAX_RECORDS, 32'(MAX_RECORDS_RESET));
    // count does not fit
    build_frame(0, 1, 1, 1'b0);
    frame[8] = 8'd100;
    run_frame(32'd20, 12);
    // second record header truncated
    build_frame(2, 1, 3, 1'b0);
    run_frame(32'd30, frame.size());
    // nonprintable name character
    build_frame(1, 3, 3, 1'b0);
    frame[21] = 8'h7F;
    run_frame(frame.size(), frame.size());
    // name too long
    drain();
    write_reg(REG_MAX_NAME_LENGTH, 32'd1);
    build_frame(1, 2, 2, 1'b0);
    run_frame(frame.size(), frame.size());
    drain();
    write_reg(REG_MAX_NAME_LENGTH, 32'(MAX_NAME_RESET));
    // unterminated name
    build_frame(1, 5, 5, 1'b0);
    run_frame(32'd22, 22);
    // empty name
    build_frame(1, 1, 1, 1'b0);
    frame[20] = 8'h00;
    run_frame(frame.size(), frame.size());
    // padding past the end
    build_frame(1, 2, 2, 1'b0);
    run_frame(32'd23, 23);
    // bad GOB tag, then too few bytes left for it
    build_frame(1, 3, 3, 1'b0);
    frame[frame.size() - 1] = 8'h3B;
    run_frame(frame.size(), frame.size());
    build_frame(1, 4, 4, 1'b0);
    run_frame(frame.size() - 1, frame.size() - 1);
    // restart in the middle of a parse
    build_frame(2, 2, 5, 1'b1);
    run_frame(frame.size(), 10);
    send_span(0, frame.size(), 1'b1);
    // length changed in the middle of a parse, then bytes after the end
    build_frame(1, 6, 6, 1'b0);
    run_frame(frame.size(), 22);
    drain();
    write_reg(REG_STREAM_LENGTH, frame.size() + 8);
    send_span(22, frame.size(), 1'b0);
    push_noise(3);
    drain();

    target = ITEM_TARGET;
    frames = 0;
    while (items_taken < target) begin
      drain();
      calm = (items_taken >= target - 150);
      in_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
      out_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
      if (frames % 6 == 5) begin
        case ($urandom_range(0, 3))
          0: value = 32'd0;
          1: value = 32'hFFFF_FFFF;
          2: value = HEADER_WORD_RESET;
          default: value = $urandom;
        endcase
        write_reg(REG_HEADER_WORD, value);
        case ($urandom_range(0, 5))
          0: value = 32'd0;
          1: value = 32'd1;
          2: value = 32'd3;
          3: value = $urandom_range(0, MAX_RECORDS_RESET);
          default: value = 32'(MAX_RECORDS_RESET);
        endcase
        write_reg(REG_MAX_RECORDS, value);
        case ($urandom_range(0, 5))
          0: value = 32'd1;
          1: value = 32'd3;
          2: value = $urandom_range(1, MAX_NAME_RESET);
          default: value = 32'(MAX_NAME_RESET);
        endcase
        write_reg(REG_MAX_NAME_LENGTH, value);
      end
      frames++;
      cap = (cf_max_records < 4) ? int'(cf_max_records) : 4;
      nrec = $urandom_range(0, cap);
      build_frame(nrec, 1, 6, 1'($urandom_range(0, 1)));
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        len = frame.size();
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        repeat (n) frame = {frame, 8'($urandom_range(0, 255))};
        if ($urandom_range(0, 9) == 0) len = 32'hFFFF_FFFF;
        else len = len + n;
        run_frame(len, frame.size());
      end else if (mode == 6) begin
        frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
        run_frame(frame.size(), frame.size());
      end else if (mode == 7) begin
        cut = $urandom_range(1, 12);
        run_frame(frame.size() - cut, frame.size());
      end else if (mode == 8) begin
        run_frame(frame.size(), $urandom_range(1, frame.size() - 1));
        send_span(0, frame.size(), 1'b1);
      end else begin
        n = $urandom_range(1, 24);
        if ($urandom_range(0, 1)) begin
          build_frame(0, 1, 1, 1'b0);
          frame = frame[0:7];
        end else begin
          frame.delete();
        end
        repeat (n) frame = {frame, 8'($urandom_range(0, 255))};
        run_frame($urandom_range(0, 40), frame.size());
      end
      if ($urandom_range(0, 7) == 0) push_noise($urandom_range(1, 3));
    end

    drain();
    if (mismatches == 0 && parsed_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
